/* sv/vn_pkg.sv */
package vn_pkg;

  localparam int CompBits  = 16;
  localparam int FracBits  = 14;
  localparam int UnitBits  = FracBits + 2;
  localparam int SumBits   = 2 * CompBits + 2;
  localparam int RootBits  = CompBits + 1;
  localparam int QuotBits  = FracBits + 1;

  typedef struct packed {
    logic signed [CompBits-1:0] comp_x;
    logic signed [CompBits-1:0] comp_y;
    logic signed [CompBits-1:0] comp_z;
  } in_t;

  typedef struct packed {
    logic signed [UnitBits-1:0] unit_x;
    logic signed [UnitBits-1:0] unit_y;
    logic signed [UnitBits-1:0] unit_z;
    logic        [CompBits-1:0] vec_length;
    logic                       zero_vector;
  } out_t;

endpackage

/* sv/vn_isqrt.sv */
module vn_isqrt #(
  parameter int SUM_BITS  = 34,
  parameter int ROOT_BITS = 17,
  parameter int SIDE_BITS = 51
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [SUM_BITS-1:0]  sum_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic [ROOT_BITS-1:0] root_o,
  output logic [SIDE_BITS-1:0] side_o
);

  localparam int RemBits = SUM_BITS + 1;
  localparam logic [RemBits-1:0] One = RemBits'(1);

  logic [RemBits-1:0]   rem_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q [ROOT_BITS];
  logic [SIDE_BITS-1:0] side_q [ROOT_BITS];

  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
    localparam int K = ROOT_BITS - 1 - s;
    logic [RemBits-1:0]   rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [SIDE_BITS-1:0] side_in;
    logic [RemBits-1:0]   trial;

    if (s == 0) begin : g_first
      assign rem_in  = {1'b0, sum_i};
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
    assign trial = (RemBits'(root_in) << (K + 1)) + (One << (2 * K));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        if (rem_in >= trial) begin
          rem_q[s]  <= rem_in - trial;
          root_q[s] <= root_in | (ROOT_BITS'(1) << K);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_BITS-1];
  assign side_o = side_q[ROOT_BITS-1];

endmodule

/* sv/vn_div_lane.sv */
module vn_div_lane #(
  parameter int MAG_BITS  = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [MAG_BITS-1:0]         mag_i,
  input  logic                        neg_i,
  input  logic [MAG_BITS-1:0]         divisor_i,
  output logic signed [FRAC_BITS+1:0] unit_o
);

  localparam int NumBits  = MAG_BITS + FRAC_BITS;
  localparam int QBits    = FRAC_BITS + 1;

  logic [NumBits-1:0]  rem_q [QBits];
  logic [QBits-1:0]    quot_q [QBits];
  logic [MAG_BITS-1:0] div_q [QBits];
  logic                neg_q [QBits];

  for (genvar s = 0; s < QBits; s++) begin : g_stage
    localparam int K = QBits - 1 - s;
    logic [NumBits-1:0]  rem_in;
    logic [QBits-1:0]    quot_in;
    logic [MAG_BITS-1:0] div_in;
    logic                neg_in;
    logic [NumBits-1:0]  shifted;

    if (s == 0) begin : g_first
      assign rem_in  = {mag_i, {FRAC_BITS{1'b0}}};
      assign quot_in = '0;
      assign div_in  = divisor_i;
      assign neg_in  = neg_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign div_in  = div_q[s-1];
      assign neg_in  = neg_q[s-1];
    end

    assign shifted = NumBits'(div_in) << K;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[s] <= div_in;
        neg_q[s] <= neg_in;
        if (rem_in >= shifted) begin
          rem_q[s]  <= rem_in - shifted;
          quot_q[s] <= quot_in | (QBits'(1) << K);
        end else begin
          rem_q[s]  <= rem_in;
          quot_q[s] <= quot_in;
        end
      end
    end
  end

  logic [FRAC_BITS+1:0] quot_ext;
  assign quot_ext = {1'b0, quot_q[QBits-1]};
  assign unit_o   = neg_q[QBits-1] ? -quot_ext : quot_ext;

endmodule

/* sv/vector3_normalize_unit.sv */
// 3D vector normalization unit.
// Input channel in_valid_i/in_ready_o carries one vector (in_t) per transfer;
// output channel out_valid_o/out_ready_i returns the unit vector with 14
// fraction bits, the floor of the length and a zero-vector flag (out_t).
// Every input transfer yields exactly one output transfer, in order.
// The pipeline holds magnitude, square and sum stages (3), one stage per
// root bit of the square root pipeline (17), one stage per quotient bit of
// the three parallel divider lanes (15), and the output register (1).
// Throughput is one vector per cycle while the receiver does not stall; items are fully independent.
// A zero vector returns zero components, zero length and the flag set.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops
// until the output register is taken; the output register lets a new
// input transfer happen in the same cycle the pending result is taken.
// Reset clears all valid bits; the pipeline is empty afterwards and ready
// at once.
module vector3_normalize_unit import vn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int Lat      = 3 + RootBits + QuotBits;
  localparam int SideBits = 3 * (CompBits + 1);

  logic           en;
  logic [Lat-1:0] valid_q;
  logic           out_valid_q;
  out_t           out_q;

  assign en = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[Lat-2:0], in_valid_i};
      out_valid_q <= valid_q[Lat-1];
    end
  end

  // magnitude stage
  logic [CompBits-1:0] comp [3];
  logic [CompBits-1:0] mag_q [3];
  logic                neg_q [3];
  assign comp[0] = in_data_i.comp_x;
  assign comp[1] = in_data_i.comp_y;
  assign comp[2] = in_data_i.comp_z;

  // square stage
  logic [2*CompBits-1:0] sq_q [3];
  logic [CompBits-1:0]   mag1_q [3];
  logic                  neg1_q [3];

  // sum stage
  logic [SumBits-1:0]  sum_q;
  logic [SideBits-1:0] side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i]  <= comp[i][CompBits-1];
        mag_q[i]  <= comp[i][CompBits-1] ? (~comp[i] + 1'b1) : comp[i];
        sq_q[i]   <= mag_q[i] * mag_q[i];
        mag1_q[i] <= mag_q[i];
        neg1_q[i] <= neg_q[i];
        side_q[i*(CompBits+1) +: CompBits+1] <= {neg1_q[i], mag1_q[i]};
      end
      sum_q <= SumBits'(sq_q[0]) + SumBits'(sq_q[1]) + SumBits'(sq_q[2]);
    end
  end

  logic [RootBits-1:0] root;
  logic [SideBits-1:0] side_s;

  vn_isqrt #(
    .SUM_BITS (SumBits),
    .ROOT_BITS(RootBits),
    .SIDE_BITS(SideBits)
  ) u_isqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .sum_i (sum_q),
    .side_i(side_q),
    .root_o(root),
    .side_o(side_s)
  );

  logic                is_zero;
  logic [CompBits-1:0] divisor;
  assign is_zero = (root == '0);
  assign divisor = is_zero ? CompBits'(1) : root[CompBits-1:0];

  logic signed [UnitBits-1:0] unit_lane [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vn_div_lane #(
      .MAG_BITS (CompBits),
      .FRAC_BITS(FracBits)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .mag_i    (side_s[i*(CompBits+1) +: CompBits]),
      .neg_i    (side_s[i*(CompBits+1) + CompBits]),
      .divisor_i(divisor),
      .unit_o   (unit_lane[i])
    );
  end

  // carry length and zero flag alongside the divider lanes
  logic [CompBits-1:0] len_dl_q  [QuotBits];
  logic                zero_dl_q [QuotBits];

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_dl_q[0]  <= root[CompBits-1:0];
      zero_dl_q[0] <= is_zero;
      for (int s = 1; s < QuotBits; s++) begin
        len_dl_q[s]  <= len_dl_q[s-1];
        zero_dl_q[s] <= zero_dl_q[s-1];
      end
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.zero_vector <= zero_dl_q[QuotBits-1];
      out_q.vec_length  <= len_dl_q[QuotBits-1];
      out_q.unit_x      <= zero_dl_q[QuotBits-1] ? '0 : unit_lane[0];
      out_q.unit_y      <= zero_dl_q[QuotBits-1] ? '0 : unit_lane[1];
      out_q.unit_z      <= zero_dl_q[QuotBits-1] ? '0 : unit_lane[2];
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* tb/vector3_normalize_unit_tb.sv */
`timescale 1ns / 100ps

module vector3_normalize_unit_tb;
  import vn_pkg::*;

  localparam int Latency   = 36;
  localparam int WatchLim  = 20000;
  localparam int NumRandom = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  out_t unit_expected_q[$];
  int   mismatch_cnt = 0;
  int   idle_cycles = 0;
  bit   stim_done = 1'b0;
  bit   hold_off_req = 1'b0;

  typedef struct {
    in_t  vec;
    bit   known;
    out_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  always #2 clk_i = ~clk_i;

  vector3_normalize_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [UnitBits-1:0] unit_comp(logic signed [CompBits-1:0] c,
                                                    longint unsigned len);
    longint unsigned mag, q;
    mag = (c < 0) ? longint'(-longint'(c)) : longint'(c);
    q = (mag << FracBits) / len;
    if (c < 0) q = -q;
    return q[UnitBits-1:0];
  endfunction

  function automatic out_t normalize_vec(in_t v);
    out_t r;
    longint signed ax, ay, az;
    longint unsigned len;
    ax = v.comp_x;
    ay = v.comp_y;
    az = v.comp_z;
    len = floor_sqrt(ax * ax + ay * ay + az * az);
    r = '0;
    if (len == 0) begin
      r.zero_vector = 1'b1;
    end else begin
      r.unit_x = unit_comp(v.comp_x, len);
      r.unit_y = unit_comp(v.comp_y, len);
      r.unit_z = unit_comp(v.comp_z, len);
      r.vec_length = len[CompBits-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CompBits-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return CompBits'($urandom_range(0, 3) - 1);
      1: return 16'sh8000;
      2: return 16'sh7fff;
      3: return CompBits'($urandom_range(0, 255) - 128);
      default: return CompBits'($urandom);
    endcase
  endfunction

  // valid stays up between back-to-back transfers; drop it only for a gap
  task automatic send_vec(in_t v, bit known, out_t res);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    unit_expected_q.push_back(known ? res : normalize_vec(v));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic dir_row_t mk(int x, int y, int z, bit known, out_t res);
    dir_row_t d;
    d.vec = '{comp_x: CompBits'(x), comp_y: CompBits'(y), comp_z: CompBits'(z)};
    d.known = known;
    d.res = res;
    return d;
  endfunction

  // stimulus
  initial begin
    out_t one_x, zero_res, neg_x;
    in_t v;
    zero_res = '{zero_vector: 1'b1, default: '0};
    one_x = '{unit_x: 16384, vec_length: 1, default: '0};
    neg_x = '{unit_x: -16384, vec_length: 32768, default: '0};
    dir_rows.push_back(mk(0, 0, 0, 1, zero_res));
    dir_rows.push_back(mk(1, 0, 0, 1, one_x));
    dir_rows.push_back(mk(-32768, 0, 0, 1, neg_x));
    dir_rows.push_back(mk(0, 32767, 0, 1,
                          '{unit_y: 16384, vec_length: 32767, default: '0}));
    dir_rows.push_back(mk(0, 0, -1, 1,
                          '{unit_z: -16384, vec_length: 1, default: '0}));
    dir_rows.push_back(mk(-32768, -32768, -32768, 0, '0));
    dir_rows.push_back(mk(32767, 32767, 32767, 0, '0));
    dir_rows.push_back(mk(-32768, 32767, -32768, 0, '0));
    dir_rows.push_back(mk(1, 1, 1, 0, '0));
    dir_rows.push_back(mk(-1, -1, -1, 0, '0));
    dir_rows.push_back(mk(3, 4, 0, 0, '0));
    dir_rows.push_back(mk(1, 2, 2, 0, '0));
    dir_rows.push_back(mk(-21845, 10922, 5461, 0, '0));
    dir_rows.push_back(mk(0, 0, 0, 1, zero_res));
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) send_vec(dir_rows[i].vec, dir_rows[i].known, dir_rows[i].res);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) hold_off_req <= 1'b1;
      if (n == 900) begin
        // pause until the pipeline drains
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (unit_expected_q.size() != 0) @(negedge clk_i);
      end
      v.comp_x = rand_comp();
      v.comp_y = rand_comp();
      v.comp_z = rand_comp();
      send_vec(v, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_ready_i <= 1'b0;
        repeat (200) @(negedge clk_i);
      end
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (unit_expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected transfer %p", out_data_o);
      end else begin
        exp_res = unit_expected_q.pop_front();
        if (out_data_o.unit_x !== exp_res.unit_x || out_data_o.unit_y !== exp_res.unit_y ||
            out_data_o.unit_z !== exp_res.unit_z ||
            out_data_o.vec_length !== exp_res.vec_length ||
            out_data_o.zero_vector !== exp_res.zero_vector) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("mismatch exp %p got %p", exp_res, out_data_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int tail;
    tail = 0;
    wait (stim_done);
    while (unit_expected_q.size() != 0 && idle_cycles < WatchLim) @(posedge clk_i);
    while (tail < 4 * Latency && idle_cycles < WatchLim) begin
      @(posedge clk_i);
      tail++;
    end
    if (idle_cycles >= WatchLim) begin
      $display("[vector3_normalize_unit] ERROR");
    end else if (mismatch_cnt == 0 && unit_expected_q.size() == 0) begin
      $display("[vector3_normalize_unit] OK");
    end else begin
      $display("[vector3_normalize_unit] ERROR");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WatchLim);
    if (!stim_done) begin
      $display("[vector3_normalize_unit] ERROR");
      $finish;
    end
  end

endmodule
